// ===== sv/lpis_pkg.sv =====
// shared types for the largest-prime-in-stream block
// controller state encoding and the command/status structs between control and datapath
package lpis_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_NEXT,
		ST_TAKE,
		ST_EMIT
	} lpis_state_t;

	typedef struct packed {
		logic load;       // latch a new transaction, divisor restarts at two
		logic div_start;  // clear remainder, load dividend shifter
		logic div_step;   // one restoring division bit
		logic next_div;   // advance divisor and its square
		logic take_max;   // value is prime: keep it if above the maximum
		logic emit;       // move maximum to the output register and clear it
	} lpis_cmd_t;

	typedef struct packed {
		logic below_two;  // value below two
		logic sq_gt;      // divisor squared exceeds value
		logic div_last;   // final division bit in this cycle
		logic rem_zero;   // divisor divides the value
		logic last;       // latched end-of-set flag
		logic out_free;   // output register can take a result now
	} lpis_status_t;

endpackage

// ===== sv/largest_prime_in_stream.sv =====
// top level: largest prime in a stream of naturals, by trial division
// instantiates lpis_ctrl and lpis_datapath, uses lpis_pkg
//
// input channel: in_valid/in_ready carry value and last_item. one transaction
// is tested at a time; in_ready is high only while the block waits for work.
// values below two are not prime. a prime above the running maximum replaces it.
// output channel: out_valid/out_ready carry largest_prime, one transaction per
// input with last_item set (0 if the set held no prime); the maximum then clears.
// steps per input transaction: a value below two ends at the first check; otherwise
// each divisor tried takes a bound check, a division pass and a remainder test,
// a prime adds a closing bound check and the update, and a last item adds an emit
// step that waits until the output register is free. divisors run 2, 3, ... while
// d*d <= value; each one costs a full pass of the bit-serial restoring divider,
// which sets the rate. worst case near 46341 divisors for a 31-bit prime.
// the output register decouples the sides: new inputs are taken while a result
// waits; a further result waits in the controller until out_ready frees it.
// reset (arst_n low) clears the maximum, drops out_valid and idles the controller.
module largest_prime_in_stream #(
	parameter int VALUE_BITS = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  last_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VALUE_BITS-1:0] largest_prime
);

	lpis_pkg::lpis_cmd_t    cmd;
	lpis_pkg::lpis_status_t status;

	lpis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lpis_datapath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.value         (value),
		.last_item     (last_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.largest_prime (largest_prime)
	);

endmodule

// ===== sv/lpis_datapath.sv =====
// datapath: value latch, divisor and square counters, serial restoring divider,
// running maximum and output register; uses lpis_pkg command/status structs
module lpis_datapath #(
	parameter int VALUE_BITS = 31
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpis_pkg::lpis_cmd_t      cmd,
	output lpis_pkg::lpis_status_t   status,
	input  logic [VALUE_BITS-1:0]    value,
	input  logic                     last_item,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [VALUE_BITS-1:0]    largest_prime
);

	localparam int DW = (VALUE_BITS + 1) / 2 + 1;   // divisor width
	localparam int SW = 2 * DW;                     // square width
	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic [VALUE_BITS-1:0] value_q;
	logic                  last_q;
	logic [DW-1:0]         div_q;
	logic [SW-1:0]         sq_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [DW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] max_q;
	logic [VALUE_BITS-1:0] out_q;
	logic                  out_valid_q;

	logic [DW:0]           trial;
	logic                  trial_ge;
	logic [DW:0]           trial_sub;

	assign trial     = {rem_q, shift_q[VALUE_BITS-1]};
	assign trial_ge  = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			last_q  <= last_item;
			div_q   <= DW'(2);
			sq_q    <= SW'(4);
		end else if (cmd.next_div) begin
			div_q <= div_q + DW'(1);
			// (d+1)^2 = d^2 + 2d + 1
			sq_q  <= sq_q + {{(SW-DW-1){1'b0}}, div_q, 1'b1};
		end
		if (cmd.div_start) begin
			shift_q <= value_q;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (cmd.div_step) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			rem_q   <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
			cnt_q   <= cnt_q + CW'(1);
		end
		if (cmd.emit) begin
			out_q <= max_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				max_q <= '0;
			end else if (cmd.take_max && (value_q > max_q)) begin
				max_q <= value_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.below_two = value_q < VALUE_BITS'(2);
	assign status.sq_gt     = sq_q > SW'(value_q);
	assign status.div_last  = cnt_q == CW'(VALUE_BITS - 1);
	assign status.rem_zero  = rem_q == '0;
	assign status.last      = last_q;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign largest_prime = out_q;

endmodule

// ===== sv/lpis_ctrl.sv =====
// controller state machine sequencing trial division for one transaction
// drives lpis_pkg::lpis_cmd_t, reads lpis_pkg::lpis_status_t
module lpis_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  lpis_pkg::lpis_status_t  status,
	output lpis_pkg::lpis_cmd_t     cmd
);

	lpis_pkg::lpis_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpis_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpis_pkg::ST_IDLE: begin
				if (in_valid) state_d = lpis_pkg::ST_CHECK;
			end
			lpis_pkg::ST_CHECK: begin
				priority if (status.below_two) begin
					state_d = status.last ? lpis_pkg::ST_EMIT : lpis_pkg::ST_IDLE;
				end else if (status.sq_gt) begin
					state_d = lpis_pkg::ST_TAKE;
				end else begin
					state_d = lpis_pkg::ST_DIV;
				end
			end
			lpis_pkg::ST_DIV: begin
				if (status.div_last) state_d = lpis_pkg::ST_NEXT;
			end
			lpis_pkg::ST_NEXT: begin
				if (status.rem_zero) begin
					state_d = status.last ? lpis_pkg::ST_EMIT : lpis_pkg::ST_IDLE;
				end else begin
					state_d = lpis_pkg::ST_CHECK;
				end
			end
			lpis_pkg::ST_TAKE: begin
				state_d = status.last ? lpis_pkg::ST_EMIT : lpis_pkg::ST_IDLE;
			end
			lpis_pkg::ST_EMIT: begin
				if (status.out_free) state_d = lpis_pkg::ST_IDLE;
			end
			default: state_d = lpis_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			lpis_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			lpis_pkg::ST_CHECK: begin
				cmd.div_start = !status.below_two && !status.sq_gt;
			end
			lpis_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			lpis_pkg::ST_NEXT: begin
				cmd.next_div = !status.rem_zero;
			end
			lpis_pkg::ST_TAKE: begin
				cmd.take_max = 1'b1;
			end
			lpis_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/lpis_checker.sv =====
// port-level checker for largest_prime_in_stream, attached by bind
// depends only on the top-level ports
module lpis_checker #(
	parameter int VALUE_BITS = 31
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [VALUE_BITS-1:0] value,
	input logic                  last_item,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] largest_prime
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(largest_prime))
		else $error("result changed or dropped while stalled");

	// one transaction at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a test is running");

	// a result appears only after a testing pass, never right after a transaction
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised directly after an input transaction");

	// a result is zero, two or odd, and never one
	a_prime_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (largest_prime != VALUE_BITS'(1)) &&
			(largest_prime[0] || largest_prime == VALUE_BITS'(2) ||
			 largest_prime == '0))
		else $error("result cannot be a prime");

endmodule

bind largest_prime_in_stream lpis_checker #(.VALUE_BITS(VALUE_BITS)) u_lpis_checker (.*);
